// ===== rtl/ssq_pkg.sv =====
// ssq_pkg: shared widths, constants, codes and types of the step sequencer.
// Depends on nothing; every other file in rtl/ takes names from it by scope.
package ssq_pkg;

    localparam int STEPS_DEFAULT = 8;

    localparam int LEVEL_W   = 8;
    localparam int LEN_W     = 4;
    localparam int GAIN_W    = 9;
    localparam int PULSE_W   = 16;
    localparam int MV_W      = 14;
    localparam int MAG_W     = 13;
    localparam int STEP_OUT_W = 3;
    localparam int GATE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // shared multiplier operand widths
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MAG_W-1:0] RANGE_LOW_MV  = 13'd1000;
    localparam logic [MAG_W-1:0] RANGE_HIGH_MV = 13'd5000;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 9'sd128;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = -9'sd128;

    // divide by 255 * 128: shift by 7, then reciprocal of 255 with one correction
    localparam int GAIN_SHIFT  = 7;
    localparam int RECIP_SHIFT = 23;
    localparam logic [MUL_B_W-1:0] RECIP_255 = MUL_B_W'((1 << RECIP_SHIFT) / 255);
    localparam int DIV_LOG2 = 8;
    localparam logic [MUL_A_W-1:0] DIVISOR = MUL_A_W'((1 << DIV_LOG2) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LEVELS,
        CFG_GATE_ENABLES,
        CFG_LENGTH,
        CFG_DIRECTION_UP,
        CFG_RANGE_FIVE_VOLT,
        CFG_GAIN,
        CFG_PULSE_TICKS
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LR,
        ST_MUL_G,
        ST_MUL_RCP,
        ST_FIX
    } cv_state_t;

    typedef struct packed {
        logic clock_level;
        logic reset_level;
        logic run_button;
        logic run_cv_level;
        logic cycle_level;
        logic dir_cv_high;
        logic tap_button;
        logic tap_gate_level;
        logic clear_button;
        logic record_on;
    } tick_in_t;

    typedef struct packed {
        logic [STEP_OUT_W-1:0] step;
        logic                  running;
        logic                  step_gate;
        logic                  loop_gate;
        logic                  eoc;
    } ctrl_status_t;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// ===== rtl/ssq_if.sv =====
// ssq_in_if / ssq_out_if: valid/ready channels of the step sequencer.
// Depends on ssq_pkg for the field widths.
interface ssq_in_if;
    logic valid;
    logic ready;
    logic clock_level;
    logic reset_level;
    logic run_button;
    logic run_cv_level;
    logic cycle_level;
    logic dir_cv_high;
    logic tap_button;
    logic tap_gate_level;
    logic clear_button;
    logic record_on;

    modport source (
        output valid, clock_level, reset_level, run_button, run_cv_level, cycle_level,
               dir_cv_high, tap_button, tap_gate_level, clear_button, record_on,
        input  ready
    );
    modport sink (
        input  valid, clock_level, reset_level, run_button, run_cv_level, cycle_level,
               dir_cv_high, tap_button, tap_gate_level, clear_button, record_on,
        output ready
    );
endinterface

interface ssq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [ssq_pkg::STEP_OUT_W-1:0]        step_index;
    logic                                  is_running;
    logic                                  step_gate;
    logic                                  loop_gate;
    logic signed [ssq_pkg::MV_W-1:0]       cv_out_mv;
    logic                                  eoc_pulse;
    logic                                  change_pulse;

    modport source (
        output valid, step_index, is_running, step_gate, loop_gate, cv_out_mv,
               eoc_pulse, change_pulse,
        input  ready
    );
    modport sink (
        input  valid, step_index, is_running, step_gate, loop_gate, cv_out_mv,
               eoc_pulse, change_pulse,
        output ready
    );
endinterface

// ===== rtl/step_sequencer_with_tap_loop_unit.sv =====
// step_sequencer_with_tap_loop_unit: top level of the step sequencer with tap loop track.
// Depends on ssq_pkg, ssq_if (channels), ssq_mul, ssq_ctrl and ssq_cv.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    ten control levels, one tick per request
//   out_ch    out   valid/ready    step, run flag, gates, held CV, eoc/change pulses
//   cfg       in    cfg_we only    cfg_index selects register, cfg_data holds value
//
// A request runs as follows when out_ch is free: the accept cycle updates the step
// logic, then three passes through the one shared multiplier (level x range, x gain,
// x reciprocal of 255) and one correction cycle that writes the output register.
// in_ch.ready is low from the accept until the result is in the output register; a
// stalled out_ch holds the block in its correction cycle. No clearing pass after
// reset: rst_n sets the control and config state at once; data registers have no reset.
module step_sequencer_with_tap_loop_unit #(
    parameter int STEPS = ssq_pkg::STEPS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ssq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssq_pkg::CFG_W-1:0]          cfg_data,
    ssq_in_if.sink                             in_ch,
    ssq_out_if.source                          out_ch
);

    // configuration registers
    logic [ssq_pkg::CFG_W-1:0]              step_levels_reg;
    logic [ssq_pkg::GATE_W-1:0]             gate_enables_reg;
    logic [ssq_pkg::LEN_W-1:0]              length_reg;
    logic                                   direction_up_reg;
    logic                                   range_five_volt_reg;
    logic signed [ssq_pkg::GAIN_W-1:0]      gain_reg;
    logic [ssq_pkg::PULSE_W-1:0]            pulse_ticks_reg;

    // output register
    logic                                   out_valid_reg;
    ssq_pkg::ctrl_status_t                  out_status_reg;
    logic signed [ssq_pkg::MV_W-1:0]        out_mv_reg;
    logic                                   out_change_reg;

    logic                                   accept;
    logic                                   out_free;
    ssq_pkg::tick_in_t                      tick;
    ssq_pkg::ctrl_status_t                  status;
    ssq_pkg::mul_req_t                      mul_req;
    logic [ssq_pkg::MUL_P_W-1:0]            product;
    logic [ssq_pkg::LEVEL_W-1:0]            level;
    logic                                   cv_idle;
    logic                                   cv_done;
    logic signed [ssq_pkg::MV_W-1:0]        cv_mv;
    logic                                   change_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_levels_reg     <= '0;
            gate_enables_reg    <= '1;
            length_reg          <= ssq_pkg::LEN_W'(8);
            direction_up_reg    <= 1'b1;
            range_five_volt_reg <= 1'b0;
            gain_reg            <= ssq_pkg::GAIN_MAX;
            pulse_ticks_reg     <= ssq_pkg::PULSE_W'(48);
        end
        else if (cfg_we)
        begin
            case (ssq_pkg::cfg_idx_t'(cfg_index))
                ssq_pkg::CFG_STEP_LEVELS:     step_levels_reg <= cfg_data;
                ssq_pkg::CFG_GATE_ENABLES:    gate_enables_reg <= cfg_data[ssq_pkg::GATE_W-1:0];
                ssq_pkg::CFG_LENGTH:          length_reg <= cfg_data[ssq_pkg::LEN_W-1:0];
                ssq_pkg::CFG_DIRECTION_UP:    direction_up_reg <= cfg_data[0];
                ssq_pkg::CFG_RANGE_FIVE_VOLT: range_five_volt_reg <= cfg_data[0];
                ssq_pkg::CFG_GAIN:            gain_reg <= $signed(cfg_data[ssq_pkg::GAIN_W-1:0]);
                ssq_pkg::CFG_PULSE_TICKS:     pulse_ticks_reg <= cfg_data[ssq_pkg::PULSE_W-1:0];
                default:                      ;  // drop writes beyond the register list
            endcase
        end
    end

    // take a request only while the CV sequencer is idle
    assign in_ch.ready = cv_idle;
    assign accept      = in_ch.valid && in_ch.ready;
    // the result register frees up in the same cycle it is taken
    assign out_free    = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        tick.clock_level    = in_ch.clock_level;
        tick.reset_level    = in_ch.reset_level;
        tick.run_button     = in_ch.run_button;
        tick.run_cv_level   = in_ch.run_cv_level;
        tick.cycle_level    = in_ch.cycle_level;
        tick.dir_cv_high    = in_ch.dir_cv_high;
        tick.tap_button     = in_ch.tap_button;
        tick.tap_gate_level = in_ch.tap_gate_level;
        tick.clear_button   = in_ch.clear_button;
        tick.record_on      = in_ch.record_on;
    end

    ssq_ctrl #(
        .STEPS(STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .tick         (tick),
        .gate_enables (gate_enables_reg),
        .length       (length_reg),
        .direction_up (direction_up_reg),
        .pulse_ticks  (pulse_ticks_reg),
        .status       (status)
    );

    // level of the step just chosen; status holds from the accept to the result
    assign level = step_levels_reg[{status.step, 3'b000} +: ssq_pkg::LEVEL_W];

    ssq_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    ssq_cv u_cv (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .out_free        (out_free),
        .level           (level),
        .range_five_volt (range_five_volt_reg),
        .gain            (gain_reg),
        .step_gate       (status.step_gate),
        .pulse_ticks     (pulse_ticks_reg),
        .product         (product),
        .mul_req         (mul_req),
        .idle            (cv_idle),
        .done            (cv_done),
        .cv_mv           (cv_mv),
        .change_bit      (change_bit)
    );

    // hold the result until out_ch takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cv_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv_done)
        begin
            out_status_reg <= status;
            out_mv_reg     <= cv_mv;
            out_change_reg <= change_bit;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.step_index   = out_status_reg.step;
    assign out_ch.is_running   = out_status_reg.running;
    assign out_ch.step_gate    = out_status_reg.step_gate;
    assign out_ch.loop_gate    = out_status_reg.loop_gate;
    assign out_ch.cv_out_mv    = out_mv_reg;
    assign out_ch.eoc_pulse    = out_status_reg.eoc;
    assign out_ch.change_pulse = out_change_reg;

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ch.ready)
        else $error("request accepted while a previous one is in flight");

    a_cv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.cv_out_mv <= 14'sd5000 && out_ch.cv_out_mv >= -14'sd5000))
        else $error("held CV outside full scale");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (32'(out_ch.step_index) < STEPS))
        else $error("step index beyond step count");

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cv_done |-> !in_ch.ready)
        else $error("result written while sequencer idle");

endmodule

// ===== rtl/ssq_mul.sv =====
// ssq_mul: the shared unsigned multiplier with a registered product.
// Depends on ssq_pkg for operand widths and the request struct.
module ssq_mul (
    input  logic                            clk,
    input  ssq_pkg::mul_req_t               req,
    output logic [ssq_pkg::MUL_P_W-1:0]     product
);

    logic [ssq_pkg::MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product_reg <= ssq_pkg::MUL_P_W'(req.a) * ssq_pkg::MUL_P_W'(req.b);
        end
    end

    assign product = product_reg;

endmodule

// ===== rtl/ssq_ctrl.sv =====
// ssq_ctrl: edge detection, step counter, run/one-shot flags, loop pattern, eoc pulse.
// Depends on ssq_pkg for the tick input and status structs.
module ssq_ctrl #(
    parameter int STEPS = ssq_pkg::STEPS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  ssq_pkg::tick_in_t                tick,
    input  logic [ssq_pkg::GATE_W-1:0]       gate_enables,
    input  logic [ssq_pkg::LEN_W-1:0]        length,
    input  logic                             direction_up,
    input  logic [ssq_pkg::PULSE_W-1:0]      pulse_ticks,
    output ssq_pkg::ctrl_status_t            status
);

    localparam int LW     = ssq_pkg::LEN_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam logic [LW-1:0] STEPS_N = LW'(STEPS);

    // bit positions in the edge history
    localparam int H_CLOCK = 0;
    localparam int H_RESET = 1;
    localparam int H_RUNB  = 2;
    localparam int H_RUNCV = 3;
    localparam int H_CYCLE = 4;
    localparam int H_TAPB  = 5;
    localparam int H_TAPG  = 6;
    localparam int H_CLEAR = 7;

    logic [7:0]                     hist_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           running_reg;
    logic                           armed_reg;
    logic [STEPS-1:0]               pattern_reg;
    logic [ssq_pkg::PULSE_W-1:0]    eoc_rem_reg;
    ssq_pkg::ctrl_status_t          status_reg;

    logic [7:0]                     lv;
    logic [7:0]                     rise;
    logic [LW-1:0]                  n;
    logic [LW-1:0]                  prev;
    logic [LW-1:0]                  step_w;
    logic [STEP_W-1:0]              step_next;
    logic                           running_next;
    logic                           armed_next;
    logic                           wrapped;
    logic                           up;
    logic                           tap;
    logic [STEPS-1:0]               pattern_next;
    logic [ssq_pkg::PULSE_W-1:0]    eoc_rem;
    logic [ssq_pkg::PULSE_W-1:0]    eoc_rem_next;
    logic                           eoc_bit;
    ssq_pkg::ctrl_status_t          status_next;

    // remainder of a small value by the length, four restoring steps
    function automatic logic [LW-1:0] mod_len(input logic [LW:0] v, input logic [LW-1:0] d);
        logic [7:0] r;
        logic [7:0] s;
        r = 8'(v);
        for (int k = 3; k >= 0; k--)
        begin
            s = 8'(d) << k;
            if (r >= s)
            begin
                r = r - s;
            end
        end
        return r[LW-1:0];
    endfunction

    always_comb
    begin
        lv = {tick.clear_button, tick.tap_gate_level, tick.tap_button, tick.cycle_level,
              tick.run_cv_level, tick.run_button, tick.reset_level, tick.clock_level};
        rise = lv & ~hist_reg;

        if (length == '0)
            n = LW'(1);
        else if (length > STEPS_N)
            n = STEPS_N;
        else
            n = length;

        running_next = running_reg ^ rise[H_RUNB] ^ rise[H_RUNCV];
        armed_next   = armed_reg;
        step_w       = LW'(step_reg);
        if (rise[H_CYCLE])
        begin
            running_next = 1'b1;
            armed_next   = 1'b1;
            step_w       = '0;
        end

        prev    = step_w;
        up      = direction_up ^ tick.dir_cv_high;
        wrapped = 1'b0;
        if (rise[H_CLOCK] && running_next)
        begin
            if (up)
            begin
                step_w  = mod_len((LW+1)'(prev) + (LW+1)'(1), n);
                wrapped = (prev == n - LW'(1));
            end
            else
            begin
                step_w  = mod_len((LW+1)'(prev) + (LW+1)'(n) - (LW+1)'(1), n);
                wrapped = (prev == '0);
            end
        end
        if (wrapped && armed_next)
        begin
            running_next = 1'b0;
            armed_next   = 1'b0;
        end
        if (rise[H_RESET] || step_w >= n)
        begin
            step_w = '0;
        end
        step_next = step_w[STEP_W-1:0];

        // eoc pulse: stretch to pulse_ticks, then count down
        eoc_rem = eoc_rem_reg;
        if (wrapped && pulse_ticks > eoc_rem)
        begin
            eoc_rem = pulse_ticks;
        end
        eoc_bit      = (eoc_rem != '0);
        eoc_rem_next = eoc_bit ? eoc_rem - ssq_pkg::PULSE_W'(1) : eoc_rem;

        // clear acts before a recorded tap on the same tick
        tap          = rise[H_TAPB] | rise[H_TAPG];
        pattern_next = pattern_reg;
        if (rise[H_CLEAR])
        begin
            pattern_next = '0;
        end
        if (tick.record_on && tap)
        begin
            pattern_next[step_next] = 1'b1;
        end

        status_next.step      = ssq_pkg::STEP_OUT_W'(step_next);
        status_next.running   = running_next;
        status_next.step_gate = gate_enables[step_next];
        status_next.loop_gate = pattern_next[step_next];
        status_next.eoc       = eoc_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= '0;
            step_reg    <= '0;
            running_reg <= 1'b1;
            armed_reg   <= 1'b0;
            pattern_reg <= '0;
            eoc_rem_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg    <= lv;
            step_reg    <= step_next;
            running_reg <= running_next;
            armed_reg   <= armed_next;
            pattern_reg <= pattern_next;
            eoc_rem_reg <= eoc_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule

// ===== rtl/ssq_cv.sv =====
// ssq_cv: sequencer that runs the CV scaling on the shared multiplier, held CV, change pulse.
// Depends on ssq_pkg for widths, constants, the state enum and the multiplier request.
module ssq_cv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                out_free,
    input  logic [ssq_pkg::LEVEL_W-1:0]         level,
    input  logic                                range_five_volt,
    input  logic signed [ssq_pkg::GAIN_W-1:0]   gain,
    input  logic                                step_gate,
    input  logic [ssq_pkg::PULSE_W-1:0]         pulse_ticks,
    input  logic [ssq_pkg::MUL_P_W-1:0]         product,
    output ssq_pkg::mul_req_t                   mul_req,
    output logic                                idle,
    output logic                                done,
    output logic signed [ssq_pkg::MV_W-1:0]     cv_mv,
    output logic                                change_bit
);

    ssq_pkg::cv_state_t                     state_reg;
    ssq_pkg::cv_state_t                     state_next;
    logic [ssq_pkg::MUL_A_W-1:0]            x_reg;
    logic signed [ssq_pkg::MV_W-1:0]        held_reg;
    logic [ssq_pkg::PULSE_W-1:0]            change_rem_reg;

    logic signed [ssq_pkg::GAIN_W-1:0]      g_clamped;
    logic signed [ssq_pkg::GAIN_W-1:0]      g_abs;
    logic                                   neg;
    logic [ssq_pkg::LEVEL_W-1:0]            mag;
    logic [ssq_pkg::MAG_W-1:0]              range_mv;
    logic [ssq_pkg::MAG_W-1:0]              q0;
    logic [ssq_pkg::MUL_A_W-1:0]            q0x;
    logic [ssq_pkg::MUL_A_W-1:0]            rem;
    logic [ssq_pkg::MAG_W-1:0]              q;
    logic signed [ssq_pkg::MV_W-1:0]        res_mv;
    logic signed [ssq_pkg::MV_W-1:0]        held_next;
    logic [ssq_pkg::PULSE_W-1:0]            crem;
    logic [ssq_pkg::PULSE_W-1:0]            crem_next;

    // gain clamp and magnitude/sign split
    always_comb
    begin
        if (gain > ssq_pkg::GAIN_MAX)
            g_clamped = ssq_pkg::GAIN_MAX;
        else if (gain < ssq_pkg::GAIN_MIN)
            g_clamped = ssq_pkg::GAIN_MIN;
        else
            g_clamped = gain;
        neg      = g_clamped[ssq_pkg::GAIN_W-1];
        g_abs    = neg ? -g_clamped : g_clamped;
        mag      = g_abs[ssq_pkg::LEVEL_W-1:0];
        range_mv = range_five_volt ? ssq_pkg::RANGE_HIGH_MV : ssq_pkg::RANGE_LOW_MV;
    end

    // quotient estimate from the reciprocal product, one correction step
    always_comb
    begin
        q0  = product[ssq_pkg::RECIP_SHIFT +: ssq_pkg::MAG_W];
        q0x = ssq_pkg::MUL_A_W'(q0);
        rem = x_reg - ((q0x << ssq_pkg::DIV_LOG2) - q0x);
        q   = (rem >= ssq_pkg::DIVISOR) ? q0 + ssq_pkg::MAG_W'(1) : q0;
        res_mv = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        held_next = step_gate ? res_mv : held_reg;

        crem = change_rem_reg;
        if (held_next != held_reg && pulse_ticks > crem)
        begin
            crem = pulse_ticks;
        end
        change_bit = (crem != '0);
        crem_next  = change_bit ? crem - ssq_pkg::PULSE_W'(1) : crem;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssq_pkg::ST_IDLE:    if (start) state_next = ssq_pkg::ST_MUL_LR;
            ssq_pkg::ST_MUL_LR:  state_next = ssq_pkg::ST_MUL_G;
            ssq_pkg::ST_MUL_G:   state_next = ssq_pkg::ST_MUL_RCP;
            ssq_pkg::ST_MUL_RCP: state_next = ssq_pkg::ST_FIX;
            ssq_pkg::ST_FIX:     if (out_free) state_next = ssq_pkg::ST_IDLE;
            default:             state_next = ssq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        idle       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ssq_pkg::ST_IDLE:
            begin
                idle = 1'b1;
            end
            ssq_pkg::ST_MUL_LR:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = ssq_pkg::MUL_A_W'(level);
                mul_req.b  = ssq_pkg::MUL_B_W'(range_mv);
            end
            ssq_pkg::ST_MUL_G:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = product[ssq_pkg::MUL_A_W-1:0];
                mul_req.b  = ssq_pkg::MUL_B_W'(mag);
            end
            ssq_pkg::ST_MUL_RCP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = product[ssq_pkg::GAIN_SHIFT +: ssq_pkg::MUL_A_W];
                mul_req.b  = ssq_pkg::RECIP_255;
            end
            ssq_pkg::ST_FIX:
            begin
                done = out_free;
            end
            default:
            begin
                idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssq_pkg::ST_IDLE;
            held_reg       <= '0;
            change_rem_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                held_reg       <= held_next;
                change_rem_reg <= crem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ssq_pkg::ST_MUL_RCP)
        begin
            x_reg <= product[ssq_pkg::GAIN_SHIFT +: ssq_pkg::MUL_A_W];
        end
    end

    assign cv_mv = held_next;

endmodule
